>>> rtl/ossv_pkg.sv
// Package for the one-shot sample voice: widths, codes, shared types and a saturation helper.
// No dependencies; compiled first.
package ossv_pkg;
   localparam int SampleFrames = 65536;
   localparam int AddrBits     = 16;
   localparam int FracBits     = 16;
   localparam int PosBits      = 34;
   localparam int OutChannels  = 2;
   localparam int CsrIdxBits   = 3;
   localparam int CsrDataBits  = 20;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0, REQ_NOTE_ON = 2'd1, REQ_NOTE_OFF = 2'd2, REQ_RENDER = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0, MODE_WAIT = 2'd1, MODE_PLAY = 2'd2
   } voice_mode_type;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_STEP = 3'd0, CSR_REVERSED = 3'd1, CSR_ON_RELEASE = 3'd2, CSR_LENGTH = 3'd3,
      CSR_CHANNELS = 3'd4, CSR_VEL_LOW = 3'd5, CSR_VEL_HIGH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [15:0]         load_address;
      logic                load_channel;
      logic signed [15:0]  load_value;
      logic [15:0]         velocity;
      logic signed [23:0]  mix_left;
      logic signed [23:0]  mix_right;
   } req_payload_type;

   typedef struct packed {
      logic signed [23:0]  out_left;
      logic signed [23:0]  out_right;
      logic [1:0]          voice_status;
      logic                ended_now;
   } rsp_payload_type;

   // per-lane control from the sequencer
   typedef struct packed {
      logic               clear;   // retrigger: zero filter memory
      logic [FracBits-1:0] frac;
      logic [15:0]        vel;
      logic [15:0]        coef;
   } lane_ctrl_type;

   function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
      if (x > 32'sd8388607) return 24'sh7FFFFF;
      if (x < -32'sd8388608) return 24'sh800000;
      return x[23:0];
   endfunction
endpackage

>>> rtl/ossv_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ossv_pkg.
interface ossv_req_if;
   logic valid;
   logic ready;
   ossv_pkg::req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ossv_rsp_if;
   logic valid;
   logic ready;
   ossv_pkg::rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/ossv_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module ossv_ram #(
   parameter int Width = 16,
   parameter int Depth = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> rtl/ossv_lane.sv
// One channel lane: interpolation, one-pole filter and velocity scaling.
// Depends on ossv_pkg; results are merged by the top level.
module ossv_lane (
   input  logic                       clock,
   input  ossv_pkg::lane_ctrl_type    ctrl,
   input  logic signed [15:0]         s1,
   input  logic signed [15:0]         s2,
   input  logic [2:0]                 phase,
   output logic signed [31:0]         contrib
);
   import ossv_pkg::*;
   logic signed [40:0] prod_ff, prod_in;
   logic signed [23:0] y_ff, y_in;
   logic signed [24:0] diff_ff, diff_in;
   logic signed [31:0] contrib_ff, contrib_in;
   logic signed [16:0] interp;
   logic signed [24:0] dsub;
   logic signed [41:0] rnd;

   // phase 1: delta*frac; 2: interp; 3: filter mul; 4: filter update; 5: scale; 6: round
   always_comb begin
      prod_in    = prod_ff;
      diff_in    = diff_ff;
      y_in       = y_ff;
      contrib_in = contrib_ff;
      interp     = '0;
      dsub       = '0;
      rnd        = '0;
      if (ctrl.clear) y_in = '0;
      case (phase)
         3'd1: prod_in = 41'((17'(s2) - 17'(s1)) * $signed({1'b0, ctrl.frac}));
         3'd2: begin
            rnd     = 42'(prod_ff) + 42'sd32768;
            interp  = 17'(s1 + (rnd >>> FracBits));
            dsub    = 25'(32'(interp) * 256 - 32'(y_ff));
            diff_in = dsub;
         end
         3'd3: prod_in = 41'(diff_ff * $signed({1'b0, ctrl.coef}));
         3'd4: begin
            rnd  = 42'(prod_ff) + 42'sd16384;
            y_in = 24'(32'(y_ff) + 32'(rnd >>> 15));
         end
         3'd5: prod_in = 41'(y_ff * $signed({1'b0, ctrl.vel}));
         3'd6: begin
            rnd        = 42'(prod_ff) + 42'sd16384;
            contrib_in = 32'(rnd >>> 15);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff    <= prod_in;
      diff_ff    <= diff_in;
      y_ff       <= y_in;
      contrib_ff <= contrib_in;
   end
   assign contrib = contrib_ff;
endmodule

>>> rtl/one_shot_sample_voice.sv
// One-shot sample voice: each transaction gives exactly one response. Loads,
// note-on, note-off and silent or ending ticks go from accept straight to the
// merge state, which registers the response. A render tick of a playing voice
// reads two frames per channel from the sample RAM (one read port per channel
// lane) in the read state, then runs a chain of three dependent multiplies
// per lane in the calc state before the merge state registers its response.
// The two lanes run side by side and the merge adds each lane's contribution
// to its mix input with 24-bit saturation. A new transaction can be accepted
// in the cycle after the response is taken.
// Unwritten sample frames read as undefined.
// Depends on ossv_pkg, ossv_if, ossv_ram, ossv_lane.
module one_shot_sample_voice (
   input  logic                 clock,
   input  logic                 reset,
   ossv_req_if.sink             req,
   ossv_rsp_if.source           rsp,
   input  logic                 csr_write,
   input  logic [ossv_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [ossv_pkg::CsrDataBits-1:0] csr_data
);
   import ossv_pkg::*;

   // configuration registers
   logic [19:0] step_ff;
   logic        rev_ff, on_rel_ff;
   logic [16:0] len_ff;
   logic [1:0]  chans_ff;
   logic [15:0] vlo_ff, vhi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 20'd65536; rev_ff <= 1'b0; on_rel_ff <= 1'b0; len_ff <= '0;
         chans_ff <= 2'd1; vlo_ff <= '0; vhi_ff <= 16'd32769;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_STEP:       step_ff  <= csr_data;
            CSR_REVERSED:   rev_ff   <= csr_data[0];
            CSR_ON_RELEASE: on_rel_ff <= csr_data[0];
            CSR_LENGTH:     len_ff   <= csr_data[16:0];
            CSR_CHANNELS:   chans_ff <= csr_data[1:0];
            CSR_VEL_LOW:    vlo_ff   <= csr_data[15:0];
            CSR_VEL_HIGH:   vhi_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_READ = 4'b0010, ST_CALC = 4'b0100, ST_DONE = 4'b1000
   } seq_state_type;

   seq_state_type   state_ff, state_in;
   req_payload_type item_ff, item_in;
   voice_mode_type  mode_ff, mode_in;
   logic signed [PosBits-1:0] pos_ff, pos_in;
   logic [15:0]     vel_ff, vel_in;
   logic [15:0]     coef_ff, coef_in;
   logic            dir_ff, dir_in;
   logic [2:0]      phase_ff, phase_in;
   logic            clear_ff, clear_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            end_flag_ff;

   logic accept;
   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept    = req.valid && req.ready;

   // clamped length and trigger helpers
   logic [16:0] len_eff;
   assign len_eff = (len_ff > 17'(SampleFrames)) ? 17'(SampleFrames) : len_ff;

   // reversed start frame, length minus two; negative for a one-frame sample
   logic signed [17:0] len_m2;
   assign len_m2 = $signed({1'b0, len_eff}) - 18'sd2;

   logic [17:0] idx_next;
   logic        tick_ends;
   assign idx_next  = {1'b0, pos_ff[PosBits-2:FracBits]} + 18'd1;
   assign tick_ends = pos_ff[PosBits-1] || (idx_next >= {1'b0, len_eff});

   // sample RAMs, one per channel lane; read address steps s1 then s2
   logic [AddrBits-1:0] rd_addr;
   logic [15:0]         rd_l, rd_r;
   logic                wr_l, wr_r;
   assign rd_addr = AddrBits'(pos_ff[FracBits+AddrBits-1:FracBits] +
                              ((phase_ff == 3'd1) ? 16'd1 : 16'd0));
   assign wr_l = accept && req.data.req_type == REQ_LOAD && !req.data.load_channel;
   assign wr_r = accept && req.data.req_type == REQ_LOAD && req.data.load_channel;

   ossv_ram #(.Width(16), .Depth(SampleFrames)) u_ram_l (
      .clock, .wr_en(wr_l), .wr_addr(req.data.load_address),
      .wr_data(req.data.load_value), .rd_addr, .rd_data(rd_l));
   ossv_ram #(.Width(16), .Depth(SampleFrames)) u_ram_r (
      .clock, .wr_en(wr_r), .wr_addr(req.data.load_address),
      .wr_data(req.data.load_value), .rd_addr, .rd_data(rd_r));

   // hold the two frames of each channel
   logic signed [15:0] l1_ff, l2_ff, r1_ff, r2_ff;
   logic               stereo;
   assign stereo = chans_ff[1];
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && phase_ff == 3'd1) begin l1_ff <= rd_l; r1_ff <= rd_r; end
      if (state_ff == ST_READ && phase_ff == 3'd2) begin l2_ff <= rd_l; r2_ff <= rd_r; end
   end

   lane_ctrl_type      ctrl;
   logic [2:0]         lane_phase;
   logic signed [31:0] c_l, c_r;
   assign ctrl.clear  = clear_ff;
   assign ctrl.frac   = pos_ff[FracBits-1:0];
   assign ctrl.vel    = vel_ff;
   assign ctrl.coef   = coef_ff;
   assign lane_phase  = (state_ff == ST_CALC) ? phase_ff : 3'd0;

   ossv_lane u_lane_l (.clock, .ctrl, .s1(l1_ff), .s2(l2_ff),
                       .phase(lane_phase), .contrib(c_l));
   ossv_lane u_lane_r (.clock, .ctrl, .s1(stereo ? r1_ff : l1_ff),
                       .s2(stereo ? r2_ff : l2_ff), .phase(lane_phase), .contrib(c_r));

   // coefficient a = (32768 + 9v + 5) / 10 via reciprocal multiply, 419431 / 2^22
   logic [20:0] a_num;
   logic [44:0] a_mul;
   logic [15:0] a_q;
   logic [15:0] vel_sat;
   assign vel_sat = (req.data.velocity > 16'd32768) ? 16'd32768 : req.data.velocity;
   assign a_num   = 21'd32773 + 21'(vel_sat) * 21'd9;
   assign a_mul   = 45'(a_num) * 45'd419431;
   assign a_q     = 16'(a_mul >> 22);

   logic trigger;
   logic in_win;
   assign in_win = (req.data.velocity >= vlo_ff) && (req.data.velocity < vhi_ff);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      coef_in      = coef_ff;
      dir_in       = dir_ff;
      phase_in     = phase_ff;
      clear_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      trigger      = 1'b0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in  = req.data;
               state_in = ST_DONE;
               case (req_kind_type'(req.data.req_type))
                  REQ_NOTE_ON: begin
                     if (in_win) begin
                        vel_in  = vel_sat;
                        coef_in = a_q;
                        if (on_rel_ff) mode_in = MODE_WAIT;
                        else trigger = 1'b1;
                     end else mode_in = MODE_IDLE;
                  end
                  REQ_NOTE_OFF: if (mode_ff == MODE_WAIT) trigger = 1'b1;
                  REQ_RENDER: begin
                     if (mode_ff == MODE_PLAY) begin
                        if (tick_ends) mode_in = MODE_IDLE;
                        else begin
                           state_in = ST_READ;
                           phase_in = 3'd0;
                        end
                     end
                  end
                  default: ;
               endcase
               if (trigger) begin
                  if (len_eff == '0) mode_in = MODE_IDLE;
                  else begin
                     dir_in   = rev_ff;
                     pos_in   = rev_ff ? {len_m2, 16'd0} : '0;
                     clear_in = 1'b1;
                     mode_in  = MODE_PLAY;
                  end
               end
            end
         end
         ST_READ: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd2) begin
               state_in = ST_CALC;
               phase_in = 3'd1;
            end
         end
         ST_CALC: begin
            phase_in = phase_ff + 3'd1;
            if (phase_ff == 3'd6) begin
               state_in = ST_DONE;
               pos_in   = dir_ff ? pos_ff - PosBits'(step_ff) : pos_ff + PosBits'(step_ff);
            end
         end
         ST_DONE: begin
            // merge: lane sums into mix, or pass the mix through
            rsp_valid_in             = 1'b1;
            rsp_data_in.voice_status = mode_ff;
            rsp_data_in.out_left     = item_ff.mix_left;
            rsp_data_in.out_right    = item_ff.mix_right;
            if (item_ff.req_type == REQ_RENDER && mode_ff == MODE_PLAY && phase_ff == 3'd7)
            begin
               rsp_data_in.out_left  = sat24(32'(item_ff.mix_left) + c_l);
               rsp_data_in.out_right = sat24(32'(item_ff.mix_right) + c_r);
            end
            rsp_data_in.ended_now = (item_ff.req_type == REQ_RENDER) && end_flag_ff;
            state_in = ST_IDLE;
            phase_in = 3'd0;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_CALC && phase_ff == 3'd6) phase_in = 3'd7;
   end

   // ended flag for the current render tick
   always_ff @(posedge clock) begin
      if (accept) end_flag_ff <= req.data.req_type == REQ_RENDER &&
                                 mode_ff == MODE_PLAY && tick_ends;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; mode_ff <= MODE_IDLE; pos_ff <= '0; vel_ff <= '0;
         coef_ff <= 16'd3277; dir_ff <= 1'b0; phase_ff <= '0; clear_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; mode_ff <= mode_in; pos_ff <= pos_in; vel_ff <= vel_in;
         coef_ff <= coef_in; dir_ff <= dir_in; phase_ff <= phase_in; clear_ff <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // never accept while a response is pending
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req.ready) else $error("accept while response pending");
   // the response is raised only from the merge state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE) else $error("stray response");
   // a tick that ends leaves the voice idle
   a_end_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.ended_now) |-> rsp_data_ff.voice_status == MODE_IDLE)
      else $error("ended while active");
endmodule

>>> test/tb_one_shot_sample_voice.sv
// Self-checking testbench for the one-shot sample voice: directed and random
// note, load and render transactions over many register settings.
// Depends on ossv_pkg, ossv_if and the one_shot_sample_voice RTL.
`timescale 1ns / 1ps

module tb_one_shot_sample_voice;
   import ossv_pkg::*;

   localparam int QuietLimit  = 5000;  // cycles with no transaction before giving up
   localparam int DrainCycles = 20;    // latency margin before a register write
   localparam int PhaseItems  = 32;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CsrIdxBits-1:0]  csr_index;
   logic [CsrDataBits-1:0] csr_data;

   ossv_req_if req_ch ();
   ossv_rsp_if rsp_ch ();

   one_shot_sample_voice DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // pending transactions for the driver, and the responses they must produce
   req_payload_type pending_reqs[$];
   rsp_payload_type voice_results[$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int quiet_cycles;
   int failures;

   // voice shadow: registers
   longint step_reg, length_reg, chans_reg, vel_low_reg, vel_high_reg;
   bit     reversed_reg, on_release_reg;
   // voice shadow: state
   logic signed [15:0] frames[int];   // key: channel * SampleFrames + frame
   longint         position;
   longint         velocity_held;
   voice_mode_type mode;
   longint         filter_y[2];
   bit             dir_latched;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic signed [23:0] clip24(input longint x);
      if (x > 8388607) return 24'sh7FFFFF;
      if (x < -8388608) return 24'sh800000;
      return x[23:0];
   endfunction

   // round to nearest, ties toward +infinity; >>> on longint floors
   function automatic longint round_shift(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint frames_held();
      return (length_reg > SampleFrames) ? SampleFrames : length_reg;
   endfunction

   function automatic int lanes_src();
      return (chans_reg <= 1) ? 1 : 2;
   endfunction

   function automatic bit tick_ends();
      return (position < 0) || ((position >>> FracBits) + 1 >= frames_held());
   endfunction

   task automatic start_voice();
      longint len;
      len = frames_held();
      if (len <= 0) begin
         mode = MODE_IDLE;
      end else begin
         dir_latched = reversed_reg;
         position = dir_latched ? ((len - 2) <<< FracBits) : 0;
         filter_y[0] = 0;
         filter_y[1] = 0;
         mode = MODE_PLAY;
      end
   endtask

   // advance the shadow voice by one transaction and return its response
   task automatic voice_step(input req_payload_type r, output rsp_payload_type o);
      longint idx, frac, a, s1, s2, interp, y, v;
      int src;
      o.out_left     = r.mix_left;
      o.out_right    = r.mix_right;
      o.ended_now    = 1'b0;
      case (req_kind_type'(r.req_type))
         REQ_LOAD: begin
            frames[int'(r.load_channel) * SampleFrames + int'(r.load_address)] = r.load_value;
         end
         REQ_NOTE_ON: begin
            if (r.velocity >= vel_low_reg && r.velocity < vel_high_reg) begin
               velocity_held = (r.velocity > 32768) ? 32768 : r.velocity;
               if (on_release_reg) mode = MODE_WAIT;
               else start_voice();
            end else begin
               mode = MODE_IDLE;
            end
         end
         REQ_NOTE_OFF: begin
            if (mode == MODE_WAIT) start_voice();
         end
         default: begin
            if (mode == MODE_PLAY) begin
               if (tick_ends()) begin
                  mode = MODE_IDLE;
                  o.ended_now = 1'b1;
               end else begin
                  idx = position >>> FracBits;
                  frac = position & ((longint'(1) << FracBits) - 1);
                  v = velocity_held;
                  a = (32768 + 9 * v + 5) / 10;
                  for (int ch = 0; ch < 2; ch++) begin
                     src = (ch < lanes_src()) ? ch : lanes_src() - 1;
                     s1 = frames[src * SampleFrames + int'(idx)];
                     s2 = frames[src * SampleFrames + int'(idx) + 1];
                     interp = s1 + round_shift((s2 - s1) * frac, FracBits);
                     y = filter_y[ch];
                     y = y + round_shift(a * (interp * 256 - y), 15);
                     filter_y[ch] = y;
                     if (ch == 0) o.out_left = clip24(longint'(r.mix_left) + round_shift(y * v, 15));
                     else o.out_right = clip24(longint'(r.mix_right) + round_shift(y * v, 15));
                  end
                  position = dir_latched ? position - step_reg : position + step_reg;
               end
            end
         end
      endcase
      o.voice_status = mode;
   endtask

   task automatic push_req(input req_kind_type kind, input int addr, input bit chan,
                           input int value, input int vel);
      req_payload_type r;
      rsp_payload_type o;
      r.req_type     = kind;
      r.load_address = addr[15:0];
      r.load_channel = chan;
      r.load_value   = value[15:0];
      r.velocity     = vel[15:0];
      // lean on full-scale mix values now and then to reach saturation
      case ($urandom_range(0, 9))
         0: r.mix_left = 24'sh7FFFFF;
         1: r.mix_left = 24'sh800000;
         default: r.mix_left = $urandom;
      endcase
      case ($urandom_range(0, 9))
         0: r.mix_right = 24'sh7FFFFF;
         1: r.mix_right = 24'sh800000;
         default: r.mix_right = $urandom;
      endcase
      voice_step(r, o);
      pending_reqs  = {pending_reqs, r};
      voice_results = {voice_results, o};
   endtask

   task automatic push_load(input int addr, input bit chan);
      push_req(REQ_LOAD, addr, chan, $urandom, $urandom);
   endtask

   // a playing tick must never read a frame that was never loaded: load it first
   task automatic push_render();
      int key;
      if (mode == MODE_PLAY && !tick_ends()) begin
         for (int src = 0; src < lanes_src(); src++)
            for (int k = 0; k < 2; k++) begin
               key = src * SampleFrames + int'(position >>> FracBits) + k;
               if (!frames.exists(key)) push_load(key % SampleFrames, src[0]);
            end
      end
      push_req(REQ_RENDER, $urandom, $urandom, $urandom, $urandom);
   endtask

   function automatic int pick_velocity();
      if ($urandom_range(0, 99) < 85 && vel_high_reg > vel_low_reg)
         return $urandom_range(int'(vel_low_reg), int'(vel_high_reg) - 1);
      return $urandom_range(0, 65535);
   endfunction

   task automatic write_csr(input csr_index_type idx, input longint value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[CsrDataBits-1:0];
      case (idx)
         CSR_STEP:       step_reg = value & 20'hFFFFF;
         CSR_REVERSED:   reversed_reg = value[0];
         CSR_ON_RELEASE: on_release_reg = value[0];
         CSR_LENGTH:     length_reg = value & 17'h1FFFF;
         CSR_CHANNELS:   chans_reg = value & 2'h3;
         CSR_VEL_LOW:    vel_low_reg = value & 16'hFFFF;
         default:        vel_high_reg = value & 16'hFFFF;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic configure(input longint step, input bit rev, input bit on_rel,
                            input longint len, input longint chans,
                            input longint vlo, input longint vhi);
      write_csr(CSR_STEP, step);
      write_csr(CSR_REVERSED, rev);
      write_csr(CSR_ON_RELEASE, on_rel);
      write_csr(CSR_LENGTH, len);
      write_csr(CSR_CHANNELS, chans);
      write_csr(CSR_VEL_LOW, vlo);
      write_csr(CSR_VEL_HIGH, vhi);
   endtask

   // hold until every response has come back, plus latency margin
   task automatic drain();
      wait (pending_reqs.size() == 0 && voice_results.size() == 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // notes with random content: loads, trigger, optional release, a run of ticks,
   // with stray note-on/note-off noise mixed in
   task automatic play_notes();
      int start;
      start = pending_reqs.size();
      while (pending_reqs.size() - start < PhaseItems) begin
         repeat ($urandom_range(0, 2)) push_load($urandom_range(0, 65535), $urandom);
         push_req(REQ_NOTE_ON, $urandom, $urandom, $urandom, pick_velocity());
         if (on_release_reg) begin
            if ($urandom_range(0, 3) == 0) push_render();
            push_req(REQ_NOTE_OFF, $urandom, $urandom, $urandom, $urandom);
         end
         repeat ($urandom_range(1, 30)) begin
            case ($urandom_range(0, 19))
               0: push_req(REQ_NOTE_OFF, $urandom, $urandom, $urandom, $urandom);
               1: push_req(REQ_NOTE_ON, $urandom, $urandom, $urandom, pick_velocity());
               default: push_render();
            endcase
         end
      end
   endtask

   // driver: advance to the next transaction once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) void'(pending_reqs.pop_front());
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data  <= pending_reqs[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with an optional long hold-off counted here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: compare each response with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (voice_results.size() == 0) begin
            $error("unexpected response %p", rsp_ch.data);
            failures++;
         end else begin
            if (rsp_ch.data.out_left !== voice_results[0].out_left) begin
               $error("out_left expected %0d got %0d",
                      voice_results[0].out_left, rsp_ch.data.out_left);
               failures++;
            end
            if (rsp_ch.data.out_right !== voice_results[0].out_right) begin
               $error("out_right expected %0d got %0d",
                      voice_results[0].out_right, rsp_ch.data.out_right);
               failures++;
            end
            if (rsp_ch.data.voice_status !== voice_results[0].voice_status) begin
               $error("voice_status expected %0d got %0d",
                      voice_results[0].voice_status, rsp_ch.data.voice_status);
               failures++;
            end
            if (rsp_ch.data.ended_now !== voice_results[0].ended_now) begin
               $error("ended_now expected %0d got %0d",
                      voice_results[0].ended_now, rsp_ch.data.ended_now);
               failures++;
            end
            void'(voice_results.pop_front());
         end
      end
   end

   // watchdog: give up after a long stretch with no transaction on either side
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
         $display("tb_one_shot_sample_voice failed");
         $finish;
      end
   end

   initial begin
      int sel;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_STEP;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_left = 0;
      quiet_cycles = 0;
      failures = 0;
      // shadow registers and state at reset
      step_reg = 65536; reversed_reg = 0; on_release_reg = 0; length_reg = 0;
      chans_reg = 1; vel_low_reg = 0; vel_high_reg = 32769;
      position = 0; velocity_held = 0; mode = MODE_IDLE;
      filter_y[0] = 0; filter_y[1] = 0; dir_latched = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: silent ticks, stray release, trigger on an empty sample,
      // load extremes
      push_render();
      push_req(REQ_NOTE_OFF, 0, 0, 0, 0);
      push_req(REQ_NOTE_ON, 0, 0, 0, 32768);
      push_render();
      push_req(REQ_LOAD, 0, 0, -32768, 0);
      push_req(REQ_LOAD, 65535, 1, 32767, 65535);
      push_req(REQ_LOAD, 1, 0, 32767, 0);
      push_req(REQ_LOAD, 0, 1, -1, 0);
      push_req(REQ_LOAD, 1, 1, -32768, 0);
      drain();

      // directed settings: short mono sample, full-scale note
      configure(65536, 0, 0, 4, 1, 0, 32769);
      push_req(REQ_NOTE_ON, 0, 0, 0, 32768);
      repeat (5) push_render();
      push_req(REQ_NOTE_ON, 0, 0, 0, 0);
      push_req(REQ_NOTE_OFF, 0, 0, 0, 0);
      repeat (2) push_render();
      drain();

      // length 1 reversed ends on the first tick
      configure(65536, 1, 0, 1, 2, 0, 32769);
      push_req(REQ_NOTE_ON, 0, 0, 0, 20000);
      push_render();
      drain();

      // random phases; idling pattern rotates every phase
      for (int phase = 0; phase < 13; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         case (phase)
            0: configure(1, 1, 0, 65536, 2, 0, 32769);            // finest step, full store
            1: configure(1048575, 0, 1, 131071, 3, 0, 32769);     // coarsest step, clamp
            2: configure(0, 0, 0, 8, 0, 1000, 20000);             // held position
            3: configure(30000, 0, 0, 2, 2, 32768, 32769);        // only full velocity
            4: configure(50000, 1, 1, 24, 1, 0, 0);               // empty window
            5: configure(65536, 0, 0, 16, 2, 0, 65535);           // velocity above 1.0
            default: begin
               sel = $urandom_range(0, 9);
               configure(sel < 4 ? 65536 : (sel < 8 ? $urandom_range(1, 200000)
                                                      : $urandom_range(1, 1048575)),
                         $urandom, $urandom,
                         $urandom_range(0, 9) == 0 ? 65536 : $urandom_range(0, 64),
                         $urandom_range(0, 3), $urandom_range(0, 4000),
                         $urandom_range(20000, 32769));
            end
         endcase
         // long receiver hold-off while the sender keeps offering
         if (phase == 1) hold_left = 400;
         play_notes();
         drain();
      end

      if (failures == 0)
         $display("tb_one_shot_sample_voice passed");
      else
         $display("tb_one_shot_sample_voice failed");
      $finish;
   end
endmodule
